>>> src/sha256_pkg.sv
`default_nettype none
package sha256_pkg;
    typedef struct packed {
        logic load_init;
        logic put_byte;
        logic [7:0] put_data;
        logic start_round;
        logic round_en;
        logic finish;
        logic clear_count;
        logic count_inc;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
        logic [60:0] count;
    } t_status;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos = 6'd56;
    localparam logic [5:0] LastPos = 6'd63;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[t];
    endfunction
endpackage
`default_nettype wire

>>> src/sha256_datapath.sv
`default_nettype none
module sha256_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sha256_pkg::t_cmd    i_cmd,
    input  wire logic [5:0]          i_round,
    input  wire logic [2:0]          i_out_sel,
    output sha256_pkg::t_status      o_status,
    output logic [31:0]              o_hash_word
);
    import sha256_pkg::*;

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [60:0] r_count;
    logic [5:0]  r_pos;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] w_t, s0, s1, w_next, t1, t2, e, a;
    assign w_t = r_w[0];
    assign s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_next = s1 + r_w[9] + s0 + r_w[0];
    assign e = r_v[4];
    assign a = r_v[0];
    assign t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(i_round) + w_t;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    // block words shift through r_w during rounds
    logic [3:0] wi;
    logic [4:0] sh;
    assign wi = r_pos[5:2];
    assign sh = 5'(24 - 8 * int'(r_pos[1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pos <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[255 - 32*i -: 32];
        end else begin
            if (i_cmd.load_init)
                for (int i = 0; i < 8; i++) r_h[i] <= InitHash[255 - 32*i -: 32];
            if (i_cmd.clear_count) begin
                r_count <= '0;
                r_pos <= '0;
            end
            // message bytes only, padding bytes are not counted
            if (i_cmd.count_inc)
                r_count <= r_count + 61'd1;
            if (i_cmd.put_byte) begin
                if (r_pos[1:0] == 2'd0)
                    r_w[wi] <= {i_cmd.put_data, 24'd0};
                else
                    r_w[wi] <= r_w[wi] | ({24'd0, i_cmd.put_data} << sh);
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.start_round)
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            if (i_cmd.round_en) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_next;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= e;
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= a;
                r_v[0] <= t1 + t2;
            end
            if (i_cmd.finish)
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    assign o_status = '{pos: r_pos, count: r_count};
    assign o_hash_word = r_h[i_out_sel];
endmodule
`default_nettype wire

>>> src/sha256_controller.sv
`default_nettype none
module sha256_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_byte_valid,
    input  wire logic               i_msg_end,
    input  wire sha256_pkg::t_status i_status,
    output sha256_pkg::t_cmd        o_cmd,
    output logic [5:0]              o_round,
    output logic [2:0]              o_out_sel,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready
);
    import sha256_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StPad  = 3'd1;
    localparam logic [2:0] StLen  = 3'd2;
    localparam logic [2:0] StRnd  = 3'd3;
    localparam logic [2:0] StFin  = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [5:0] r_round, n_round;
    logic       r_end, n_end;
    logic [2:0] r_ret, n_ret;
    logic [63:0] r_bits, n_bits;
    logic [2:0] r_sel, n_sel;

    assign o_round = r_round;
    assign o_out_sel = r_sel;
    assign o_ready = (r_state == StIdle);
    assign o_out_valid = (r_state == StOut);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_end = r_end;
        n_ret = r_ret;
        n_bits = r_bits;
        n_sel = r_sel;
        o_cmd = '0;
        case (r_state)
            StIdle: begin
                if (i_valid) begin
                    n_bits = {i_status.count + 61'(i_byte_valid), 3'd0};
                    n_end = i_msg_end;
                    if (i_byte_valid) begin
                        o_cmd.put_byte = 1'b1;
                        o_cmd.put_data = i_data_byte;
                        o_cmd.count_inc = 1'b1;
                        if (i_status.pos == LastPos) begin
                            n_state = StRnd;
                            n_ret = i_msg_end ? StPad : StIdle;
                            o_cmd.start_round = 1'b1;
                            n_round = '0;
                        end else if (i_msg_end) begin
                            n_state = StPad;
                        end
                    end else if (i_msg_end) begin
                        n_state = StPad;
                    end
                    n_sel = '0;
                end
            end
            StPad: begin
                // 0x80 marker then zeros up to the length field
                o_cmd.put_byte = 1'b1;
                o_cmd.put_data = r_end ? PadByte : 8'd0;
                n_end = 1'b0;
                if (i_status.pos == LastPos) begin
                    n_state = StRnd;
                    n_ret = StPad;
                    o_cmd.start_round = 1'b1;
                    n_round = '0;
                end else if (i_status.pos == LenPos - 6'd1) begin
                    n_state = StLen;
                end
            end
            StLen: begin
                o_cmd.put_byte = 1'b1;
                o_cmd.put_data = r_bits[63:56];
                n_bits = {r_bits[55:0], 8'd0};
                if (i_status.pos == LastPos) begin
                    n_state = StRnd;
                    n_ret = StOut;
                    o_cmd.start_round = 1'b1;
                    n_round = '0;
                end
            end
            StRnd: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == LastPos) n_state = StFin;
            end
            StFin: begin
                o_cmd.finish = 1'b1;
                n_state = r_ret;
            end
            StOut: begin
                if (i_out_ready) begin
                    n_sel = r_sel + 3'd1;
                    if (r_sel == 3'd7) begin
                        n_state = StIdle;
                        o_cmd.load_init = 1'b1;
                        o_cmd.clear_count = 1'b1;
                    end
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_round <= '0;
            r_end <= 1'b0;
            r_ret <= StIdle;
            r_sel <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_end <= n_end;
            r_ret <= n_ret;
            r_sel <= n_sel;
        end
        r_bits <= n_bits;
    end
endmodule
`default_nettype wire

>>> src/sha256_message_hasher.sv
`default_nettype none
// sha-256 hasher taking one message byte per transfer. the transfer that fills
// a 64-byte block waits out its compression on the single shared round unit,
// the rounds and then the chaining add. on msg_end the block pads itself one
// byte per cycle outside compressions (one or two compressions in all), then
// shows the eight digest words, word 0 first, one per output transfer, with
// digest_last on word 7. input is not taken while padding, compressing or
// sending the digest.
module sha256_message_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_msg_end,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_digest_last
);
    import sha256_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic [5:0] round;
    logic [2:0] sel;

    sha256_controller u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_byte, .i_byte_valid,
        .i_msg_end, .i_status(status), .o_cmd(cmd), .o_round(round),
        .o_out_sel(sel), .o_out_valid(o_valid), .i_out_ready(i_ready)
    );

    // datapath also keeps the message length counter (message bytes only)
    sha256_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_round(round), .i_out_sel(sel),
        .o_status(status), .o_hash_word(o_digest_word)
    );

    assign o_word_index = sel;
    assign o_digest_last = (sel == 3'd7);

    // input and output never both active
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready during digest output");
    // a round pass never overlaps byte loading
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.round_en && cmd.put_byte)) else $error("round while loading");
    // digest words step only on output transfer
    a_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_word_index)))
        else $error("digest word index moved while stalled");
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [7:0] i_data_byte = '0;
    logic i_byte_valid = 1'b0;
    logic i_msg_end = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0] o_word_index;
    logic o_digest_last;

    always #2 i_clk = ~i_clk;

    sha256_message_hasher DUT (.*);

    typedef struct packed {
        logic [7:0] data;
        logic       bval;
        logic       mend;
    } t_byte_xfer;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_xfer;

    localparam logic [31:0] HashInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // predictor state
    logic [31:0] hash_st [8];
    logic [31:0] blk_words [16];
    logic [60:0] msg_bytes;

    t_byte_xfer   pending_bytes [$];
    t_digest_xfer digest_expected [$];

    int n_mismatch = 0;
    int n_digests = 0;
    int n_sent = 0;
    int n_words = 0;
    bit calm = 1'b0;   // no idling in the last part of the run

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk_words into hash_st
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = blk_words[t];
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = hash_st[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_st[i] += v[i];
    endfunction

    function automatic void load_byte(input logic [5:0] pos, input logic [7:0] b);
        if (pos[1:0] == 2'd0) blk_words[pos[5:2]] = {b, 24'h0};
        else blk_words[pos[5:2]] |= 32'(b) << (24 - 8 * pos[1:0]);
        if (pos == 6'd63) compress_block();
    endfunction

    function automatic void hash_reset();
        for (int i = 0; i < 8; i++) hash_st[i] = HashInit[i];
        msg_bytes = '0;
    endfunction

    // advance the hash on one byte transfer and queue any digest it yields
    function automatic void predict_digest(input t_byte_xfer x);
        logic [5:0] pos;
        logic [63:0] bits;
        if (x.bval) begin
            load_byte(msg_bytes[5:0], x.data);
            msg_bytes++;
        end
        if (!x.mend) return;
        pos = msg_bytes[5:0];
        load_byte(pos, 8'h80);
        pos++;
        while (pos != 6'd56) begin
            load_byte(pos, 8'h00);
            pos++;
        end
        bits = {msg_bytes, 3'b000};
        for (int i = 7; i >= 0; i--) begin
            load_byte(pos, bits[8*i +: 8]);
            pos++;
        end
        for (int i = 0; i < 8; i++)
            digest_expected.push_back('{hash_st[i], 3'(i), i == 7});
        n_digests++;
        hash_reset();
    endfunction

    task automatic queue_msg(input int len, input bit end_with_byte, input bit pattern);
        for (int i = 0; i < len; i++) begin
            t_byte_xfer x;
            x.data = pattern ? 8'(i * 37 + 255) : 8'($urandom);
            x.bval = 1'b1;
            x.mend = end_with_byte && (i == len - 1);
            pending_bytes.push_back(x);
        end
        if (!end_with_byte || len == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    // driver: random idle bursts on the send side
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) n_sent++;
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 15) == 0) begin
                    send_gap <= $urandom_range(0, 16);
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    t_byte_xfer x;
                    x = pending_bytes.pop_front();
                    predict_digest(x);
                    i_valid <= 1'b1;
                    i_data_byte <= x.data;
                    i_byte_valid <= x.bval;
                    i_msg_end <= x.mend;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each digest transfer; random stall bursts on ready
    int stall = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                t_digest_xfer got, exp_w;
                got = '{o_digest_word, o_word_index, o_digest_last};
                n_words++;
                if (digest_expected.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected digest word %h", got.word);
                end else begin
                    exp_w = digest_expected.pop_front();
                    if (got !== exp_w) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                exp_w.word, exp_w.idx, exp_w.last,
                                got.word, got.idx, got.last);
                    end
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                stall <= $urandom_range(0, 16);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int lens [8];
        hash_reset();
        for (int i = 0; i < 16; i++) blk_words[i] = '0;
        // directed: empty message, byte with end, padding edges at 55/56/63/64
        lens = '{0, 1, 3, 55, 56, 63, 64, 65};
        queue_msg(0, 1'b0, 1'b1);
        queue_msg(1, 1'b1, 1'b1);
        queue_msg(3, 1'b0, 1'b1);
        for (int i = 3; i < 8; i++) queue_msg(lens[i], i[0], 1'b1);
        // idle items: neither byte nor end
        pending_bytes.push_back('{8'h00, 1'b0, 1'b0});
        pending_bytes.push_back('{8'hff, 1'b0, 1'b0});
        queue_msg(2, 1'b1, 1'b0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // random messages, mostly short, some noise items in between
        for (int m = 0; m < 6; m++) begin
            int len;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
            for (int i = 0; i < len; i++) begin
                pending_bytes.push_back('{8'($urandom), 1'b1, 1'b0});
                if ($urandom_range(0, 9) == 0)
                    pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
            end
            if ($urandom_range(0, 1) && len > 0) pending_bytes[$].mend = 1'b1;
            else pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
        end
        wait (pending_bytes.size() < 60);
        calm = 1'b1;
        wait (pending_bytes.size() == 0 && digest_expected.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("sent %0d byte transfers, checked %0d digests (%0d words)",
            n_sent, n_digests, n_words);
        if (n_mismatch == 0 && digest_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
